>>> src/byte_fifo_with_flow_control_defines.svh
// Assertion macros used by the verification checker of the byte FIFO.
// No dependencies.
`ifndef BYTE_FIFO_WITH_FLOW_CONTROL_DEFINES_SVH
`define BYTE_FIFO_WITH_FLOW_CONTROL_DEFINES_SVH

// clocked check, masked while reset is asserted
`define BFIFO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define BFIFO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/bfifo_pkg.sv
// Shared constants, command type and helper functions for the byte FIFO.
// No dependencies.
package bfifo_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int OP_W   = 3;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 11;
    localparam int TOT_W  = 48;
    localparam int SUM_W  = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;

    // s_tdata: data_in, count
    localparam int DIN_LSB   = 0;
    localparam int CNT_LSB   = DIN_LSB + DATA_W;
    localparam int S_FIELD_W = CNT_LSB + CNT_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;

    // m_tdata: data_out, accepted, occupancy, space_left, totals, ended flag
    localparam int M_FIELD_W = DATA_W + 3 * CNT_W + 2 * TOT_W + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP   = 3'd3;
    localparam logic [OP_W-1:0] OP_END   = 3'd4;

    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    typedef struct packed {
        logic load;
        logic commit;
    } bfifo_cmd_t;

    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [SUM_W-1:0] a);
        logic [SUM_W-1:0] d;
        d = SUM_W'(DEPTH);
        wrap_addr = (a >= d) ? ADDR_W'(a - d) : ADDR_W'(a);
    endfunction

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] tot,
                                                 input logic [CNT_W-1:0] inc);
        logic [TOT_W:0] s;
        s = {1'b0, tot} + (TOT_W + 1)'(inc);
        sat_add = s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap);
        eff_cap = (int'(cap) > DEPTH) ? CNT_W'(DEPTH) : cap;
    endfunction

endpackage

>>> src/bfifo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bfifo_ctrl.sv
// Sequencer for the byte FIFO: item acceptance, execution and result slot.
// Depends on bfifo_pkg.
module bfifo_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output bfifo_pkg::bfifo_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept, commit;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign cmd.load   = accept;
    assign cmd.commit = commit;

endmodule

>>> src/bfifo_dp.sv
// Datapath of the byte FIFO: pointers, totals, capacity, byte store, result register.
// Depends on bfifo_pkg and bfifo_ram.
module bfifo_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bfifo_pkg::bfifo_cmd_t            cmd,
    input  logic [bfifo_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [bfifo_pkg::OP_W-1:0]       s_tuser,
    input  logic                             cfg_we,
    input  logic [bfifo_pkg::CNT_W-1:0]      cfg_data,
    output logic [bfifo_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                       m_tuser,
    output logic                             m_tlast
);

    logic [bfifo_pkg::OP_W-1:0]   op_reg;
    logic [bfifo_pkg::DATA_W-1:0] din_reg;
    logic [bfifo_pkg::CNT_W-1:0]  cnt_reg;

    logic [bfifo_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [bfifo_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic [bfifo_pkg::TOT_W-1:0]  wt_reg, wt_next;
    logic [bfifo_pkg::TOT_W-1:0]  rt_reg, rt_next;
    logic                         ended_reg, ended_next;
    logic [bfifo_pkg::CNT_W-1:0]  cap_reg;

    logic [bfifo_pkg::M_TDATA_W-1:0] tdata_reg;
    logic                            tuser_reg;
    logic                            tlast_reg;

    logic [bfifo_pkg::CNT_W-1:0]  cnt_in, peek_off, cap, n_pop, acc, space;
    logic [bfifo_pkg::ADDR_W-1:0] raddr, waddr;
    logic [bfifo_pkg::DATA_W-1:0] rdata, dout;
    logic                         valid, we;

    assign cnt_in   = s_tdata[bfifo_pkg::CNT_LSB +: bfifo_pkg::CNT_W];
    assign peek_off = ((s_tuser == bfifo_pkg::OP_PEEK) && (cnt_in < fill_reg)) ? cnt_in : '0;
    assign raddr    = bfifo_pkg::wrap_addr(bfifo_pkg::SUM_W'(head_reg)
                                           + bfifo_pkg::SUM_W'(peek_off));
    assign waddr    = bfifo_pkg::wrap_addr(bfifo_pkg::SUM_W'(head_reg)
                                           + bfifo_pkg::SUM_W'(fill_reg));
    assign cap      = bfifo_pkg::eff_cap(cap_reg);
    assign n_pop    = (cnt_reg < fill_reg) ? cnt_reg : fill_reg;
    assign we       = cmd.commit && (op_reg == bfifo_pkg::OP_WRITE) && (fill_reg < cap);

    bfifo_ram #(
        .WIDTH (bfifo_pkg::DATA_W),
        .DEPTH (bfifo_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (din_reg),
        .re    (cmd.load),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        head_next  = head_reg;
        fill_next  = fill_reg;
        wt_next    = wt_reg;
        rt_next    = rt_reg;
        ended_next = ended_reg;
        valid      = 1'b0;
        acc        = '0;
        case (op_reg)
            bfifo_pkg::OP_WRITE: begin
                if (fill_reg < cap) begin
                    fill_next = fill_reg + 1'b1;
                    acc       = 11'd1;
                    wt_next   = bfifo_pkg::sat_add(wt_reg, 11'd1);
                end
            end
            bfifo_pkg::OP_READ: begin
                if (fill_reg != '0) begin
                    valid     = 1'b1;
                    head_next = bfifo_pkg::wrap_addr(bfifo_pkg::SUM_W'(head_reg)
                                                     + bfifo_pkg::SUM_W'(1));
                    fill_next = fill_reg - 1'b1;
                    acc       = 11'd1;
                    rt_next   = bfifo_pkg::sat_add(rt_reg, 11'd1);
                end
            end
            bfifo_pkg::OP_PEEK: begin
                valid = (cnt_reg < fill_reg);
            end
            bfifo_pkg::OP_POP: begin
                head_next = bfifo_pkg::wrap_addr(bfifo_pkg::SUM_W'(head_reg)
                                                 + bfifo_pkg::SUM_W'(n_pop));
                fill_next = fill_reg - n_pop;
                acc       = n_pop;
                rt_next   = bfifo_pkg::sat_add(rt_reg, n_pop);
            end
            bfifo_pkg::OP_END: begin
                ended_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign dout  = valid ? rdata : '0;
    assign space = (fill_next < cap) ? (cap - fill_next) : '0;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_tuser;
            din_reg <= s_tdata[bfifo_pkg::DIN_LSB +: bfifo_pkg::DATA_W];
            cnt_reg <= cnt_in;
        end
        if (cmd.commit) begin
            tdata_reg <= {{bfifo_pkg::M_PAD_W{1'b0}}, ended_next, rt_next, wt_next,
                          space, fill_next, acc, dout};
            tuser_reg <= valid;
            tlast_reg <= ended_next && (fill_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            fill_reg  <= '0;
            wt_reg    <= '0;
            rt_reg    <= '0;
            ended_reg <= 1'b0;
            cap_reg   <= bfifo_pkg::CAP_RESET;
        end else begin
            if (cmd.commit) begin
                head_reg  <= head_next;
                fill_reg  <= fill_next;
                wt_reg    <= wt_next;
                rt_reg    <= rt_next;
                ended_reg <= ended_next;
            end
            if (cfg_we) begin
                cap_reg <= cfg_data;
            end
        end
    end

    assign m_tdata    = tdata_reg;
    assign m_tuser[0] = tuser_reg;
    assign m_tlast    = tlast_reg;

endmodule

>>> src/byte_fifo_with_flow_control.sv
// Bounded byte FIFO with end-of-input marking; top level.
// Depends on bfifo_pkg, bfifo_ctrl, bfifo_dp (and bfifo_ram through bfifo_dp).
// An accepted item moves the sequencer to its execute state; m_tvalid is registered from the
// commit there, which waits for a free result slot. No new item is taken until then (s_tready low).
// Reset: pointers, totals and ended flag cleared, capacity 1024; store contents kept.
// Capacity writes are taken in any cycle (cfg_ready is always high).
module byte_fifo_with_flow_control (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bfifo_pkg::S_TDATA_W-1:0]  s_tdata,   // data_in, count, zero pad
    input  logic [bfifo_pkg::OP_W-1:0]       s_tuser,   // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // data_out, accepted, occupancy, space_left, total_written, total_read,
    // ended flag, zero pad
    output logic [bfifo_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                       m_tuser,   // data_valid
    output logic                             m_tlast,   // end_of_stream
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bfifo_pkg::CNT_W-1:0]      cfg_data   // capacity
);

    bfifo_pkg::bfifo_cmd_t cmd;

    assign cfg_ready = 1'b1;

    bfifo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bfifo_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> src/bfifo_checker.sv
// Port-level checks for the byte FIFO, bound to the top level.
// Depends on bfifo_pkg and byte_fifo_with_flow_control_defines.svh.
`include "byte_fifo_with_flow_control_defines.svh"

module bfifo_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [bfifo_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [bfifo_pkg::OP_W-1:0]       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bfifo_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [0:0]                       m_tuser,
    input logic                             m_tlast,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [bfifo_pkg::CNT_W-1:0]      cfg_data
);

    `BFIFO_ASSERT(a_result_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `BFIFO_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `BFIFO_ASSERT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")
    `BFIFO_ASSERT(a_eos, aclk, aresetn, m_tvalid |-> m_tlast == (m_tdata[137] && m_tdata[29:19] == 11'd0), "end_of_stream disagrees with status")
    `BFIFO_ASSERT(a_no_data, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0, "data_out nonzero without data_valid")

endmodule

bind byte_fifo_with_flow_control bfifo_checker u_bfifo_checker (.*);
